@@ hdl/zrf_pkg.sv @@
package zrf_pkg;

    // Largest supported frame dimension and the widths that follow from it
    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = CNT_W + 1;

    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 3;
    localparam int PIX_W   = CHAN_W * NCHAN;
    localparam int NTAPS   = 5;

    // Configuration register map
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = DIM_W'(480);

    localparam logic [CHAN_W-1:0] WHITE = {CHAN_W{1'b1}};

    // Sum of five channels divided by 5 as (sum * 3277) >> 14; exact for sum <= 1275
    localparam int SUM_W      = CHAN_W + 3;
    localparam int MUL_W      = 12;
    localparam int PROD_W     = SUM_W + MUL_W;
    localparam int DIV5_SHIFT = 14;
    localparam logic [MUL_W-1:0] DIV5_MUL = MUL_W'(3277);

    // Index of the last result an input word produces (0 to 2)
    localparam int IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_WHITE,
        MODE_MEAN,
        MODE_LEFT,
        MODE_RIGHT
    } mode_t;

    // Work handed from the front end to the pixel unit
    typedef struct packed {
        logic [NTAPS-1:0][PIX_W-1:0] taps;      // taps[0] is column-2, taps[4] column+2
        mode_t                       mode;      // mode of the first result
        logic [IDX_W-1:0]            last_idx;  // index of the job's last result
        logic                        row_end;   // job ends a row
        logic                        frame_end; // job ends the frame
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;       // blue low, then green, then red
        logic             row_end;
        logic             frame_end;
    } res_t;

endpackage

@@ hdl/zrf_front.sv @@
module zrf_front
    import zrf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,
    input  logic [DIM_W-1:0] width,
    input  logic [DIM_W-1:0] height,
    input  logic             out_ready,
    output logic             job_valid,
    output job_t             job,
    output logic [IDX_W-1:0] res_idx
);

    logic [3:0][PIX_W-1:0] win_reg;
    logic [CNT_W-1:0]      col_reg;
    logic [CNT_W-1:0]      row_reg;
    logic                  job_valid_reg;
    job_t                  job_reg;
    logic [IDX_W-1:0]      idx_reg;

    logic             accept;
    logic             adv;
    logic             job_done;
    logic             last_col;
    logic             last_row;
    logic             col_ge2;
    logic             border;
    logic             emit_any;
    job_t             job_next;

    assign adv      = job_valid_reg && out_ready;
    assign job_done = adv && (idx_reg == job_reg.last_idx);
    assign s_tready = !job_valid_reg || job_done;
    assign accept   = s_tvalid && s_tready;

    assign last_col = ({1'b0, col_reg} + DIM_W'(1)) >= width;
    assign last_row = ({1'b0, row_reg} + DIM_W'(1)) >= height;
    assign col_ge2  = col_reg >= CNT_W'(2);
    assign emit_any = col_ge2 || last_col;
    // Border test for column col-2
    assign border   = (row_reg < CNT_W'(2)) || (({1'b0, row_reg} + DIM_W'(2)) >= height)
                   || (col_reg < CNT_W'(4)) || ({1'b0, col_reg} >= width);

    always_comb begin
        job_next.taps[0]   = win_reg[3];
        job_next.taps[1]   = win_reg[2];
        job_next.taps[2]   = win_reg[1];
        job_next.taps[3]   = win_reg[0];
        job_next.taps[4]   = s_tdata;
        job_next.row_end   = last_col;
        job_next.frame_end = last_col && last_row;
        if (!last_col) begin
            job_next.last_idx = IDX_W'(0);
        end else if (col_ge2) begin
            job_next.last_idx = IDX_W'(2);
        end else begin
            job_next.last_idx = {1'b0, col_reg[0]};
        end
        if (!col_ge2 || border) begin
            job_next.mode = MODE_WHITE;
        end else begin
            case (row_reg[1:0])
                2'd1:    job_next.mode = MODE_LEFT;
                2'd3:    job_next.mode = MODE_RIGHT;
                default: job_next.mode = MODE_MEAN;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (accept) begin
            win_reg       <= {win_reg[2:0], s_tdata};
            job_valid_reg <= emit_any;
            job_reg       <= job_next;
            idx_reg       <= '0;
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + CNT_W'(1);
            end else begin
                col_reg <= col_reg + CNT_W'(1);
            end
        end else if (job_done) begin
            job_valid_reg <= 1'b0;
        end else if (adv) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;
    assign res_idx   = idx_reg;

endmodule

@@ hdl/zrf_pixel.sv @@
module zrf_pixel
    import zrf_pkg::*;
(
    input  job_t             job,
    input  logic [IDX_W-1:0] res_idx,
    output res_t             res
);

    logic [NCHAN-1:0][SUM_W-1:0]  sum;
    logic [NCHAN-1:0][PROD_W-1:0] prod;
    logic [NCHAN-1:0][CHAN_W-1:0] mean;
    logic [PIX_W-1:0]             pix_first;
    logic                         is_last;

    always_comb begin
        for (int k = 0; k < NCHAN; k++) begin
            sum[k] = SUM_W'(job.taps[0][CHAN_W*k +: CHAN_W])
                   + SUM_W'(job.taps[1][CHAN_W*k +: CHAN_W])
                   + SUM_W'(job.taps[2][CHAN_W*k +: CHAN_W])
                   + SUM_W'(job.taps[3][CHAN_W*k +: CHAN_W])
                   + SUM_W'(job.taps[4][CHAN_W*k +: CHAN_W]);
            prod[k] = PROD_W'(sum[k]) * PROD_W'(DIV5_MUL);
            mean[k] = prod[k][DIV5_SHIFT +: CHAN_W];
        end
    end

    always_comb begin
        case (job.mode)
            MODE_MEAN:  pix_first = mean;
            MODE_LEFT:  pix_first = job.taps[0];
            MODE_RIGHT: pix_first = job.taps[NTAPS-1];
            default:    pix_first = {NCHAN{WHITE}};
        endcase
    end

    // Only the first result of a job can lie inside the frame; flushed ones are white
    assign is_last       = res_idx == job.last_idx;
    assign res.pix       = (res_idx == IDX_W'(0)) ? pix_first : {NCHAN{WHITE}};
    assign res.row_end   = job.row_end && is_last;
    assign res.frame_end = job.frame_end && is_last;

endmodule

@@ hdl/zrf_out.sv @@
module zrf_out
    import zrf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  res_t             in_res,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic out_valid_reg;
    res_t out_reg;
    logic skid_valid_reg;
    res_t skid_reg;

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
                out_reg       <= in_res;
            end
        end else if (in_valid && in_ready) begin
            // hold the word that arrived while the output was stalled
            skid_valid_reg <= 1'b1;
            skid_reg       <= in_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.pix;
    assign m_tlast  = out_reg.row_end;
    assign m_tuser  = out_reg.frame_end;

endmodule

@@ hdl/zigzag_row_filter.sv @@
// Zigzag row filter for a raster stream of BGR pixels.
// Input words arrive on s_* one pixel each; output words leave on m_* in the
// same raster order, two columns behind the input. Rows 0 and 2 (mod 4) give
// the mean of five horizontal neighbors, row 1 copies the pixel two columns to
// the left, row 3 the one two columns to the right, and a two-pixel frame on
// every side is white. m_tlast marks the last pixel of a row, m_tuser the last
// pixel of the frame.
// cfg_* writes image_width (index 0) and image_height (index 1); write them
// only while the stream is idle. cfg_ready is always high.
// Throughput: one input word per cycle while the receiver keeps m_tready high. The
// input word that ends a row also flushes the row's pending pixels and produces
// up to three output words, one per cycle, so s_tready drops at each row end.
// The first result word of an accepted input word passes the job register
// and then the output register on its way to m_*; flushed words follow one
// per cycle while m_tready is high.
// A two-word output buffer decouples m_tready from s_tready; with the
// receiver stalled the block takes words until the job register and the
// buffer are full, and nothing is lost.
// Reset clears the counters, the pixel window and all valid flags, and loads
// width 640 and height 480.
module zigzag_row_filter
    import zrf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // pixel input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,   // blue_in, green_in, red_in
    // filtered output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,   // blue_out, green_out, red_out
    output logic                 m_tlast,   // row_end
    output logic                 m_tuser,   // frame_end
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;

    logic             out_ready;
    logic             job_valid;
    job_t             job;
    logic [IDX_W-1:0] res_idx;
    res_t             res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions to 1 .. MAX_DIM
    always_comb begin
        if (image_width_reg == '0) begin
            width = DIM_W'(1);
        end else if (image_width_reg > DIM_W'(MAX_DIM)) begin
            width = DIM_W'(MAX_DIM);
        end else begin
            width = image_width_reg;
        end
        if (image_height_reg == '0) begin
            height = DIM_W'(1);
        end else if (image_height_reg > DIM_W'(MAX_DIM)) begin
            height = DIM_W'(MAX_DIM);
        end else begin
            height = image_height_reg;
        end
    end

    // Window, counters and the job register
    zrf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .width     (width),
        .height    (height),
        .out_ready (out_ready),
        .job_valid (job_valid),
        .job       (job),
        .res_idx   (res_idx)
    );

    // Mean, copy or white for the current result of the job
    zrf_pixel u_pixel (
        .job     (job),
        .res_idx (res_idx),
        .res     (res)
    );

    // Output register with skid buffer
    zrf_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (job_valid),
        .in_ready (out_ready),
        .in_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // A job never steps past its last result
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> (res_idx <= job.last_idx))
        else $error("result index past end of job");

    // The buffer only refuses words while the output holds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_ready |-> m_tvalid)
        else $error("skid full with empty output");

    // Frame end only comes with a row end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && res.frame_end) |-> res.row_end)
        else $error("frame end without row end");

    // Every accepted word starts its job at the first result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!job_valid || res_idx == IDX_W'(0)))
        else $error("new job did not start at its first result");

endmodule

@@ tb/sv/zigzag_row_filter_tb.sv @@
module zigzag_row_filter_tb;
    import zrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run control
    localparam int CYCLE_LIMIT   = 200_000;  // far above the slowest correct run
    localparam int SETTLE_CYCLES = 8;        // job register + output buffer, plus margin
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 150;      // long receiver stall to back up the block
    localparam int IDLE_PERCENT  = 27;
    localparam int QUIET_START   = 400;      // window with no idling on either side
    localparam int QUIET_END     = 1200;
    localparam int RANDOM_WORDS  = 460;
    localparam int REPORT_MAX    = 10;

    // An index outside the register map; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(2);

    // Directed pixel words, consumed in order by the directed phases below
    localparam int N_DIRECTED = 29;
    localparam logic [PIX_W-1:0] DIRECTED_WORDS [N_DIRECTED] = '{
        // default 640x480, first row: all border
        24'hFFFFFF, 24'h000000, 24'h807F01,
        // width and height 0 (used as 1): flush past the last column, one-pixel frames
        24'h123456, 24'hABCDEF,
        // width 2, height 8191 (used as MAX_DIM): narrow rows, two words per flush
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h010203,
        // width 5, row 2: mean with the largest sums
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFEFFFF,
        // row 3: copy from two columns to the right
        24'h010203, 24'h102030, 24'hA0B0C0, 24'h0F1E2D, 24'h00FF80,
        // width 1: skip row 4 in one word
        24'h555555,
        // width 5, row 5: copy from two columns to the left
        24'hC3A5F0, 24'h3C5A0F, 24'h777777, 24'h000000, 24'h888888,
        // width 4, height 3: row 6 is past the last row, so it ends the frame
        24'h0F0F0F, 24'hF0F0F0, 24'hAAAAAA, 24'h5A5A5A
    };

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;   // blue_in, green_in, red_in
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIX_W-1:0]     m_tdata;          // blue_out, green_out, red_out
    logic                 m_tlast;          // row_end
    logic                 m_tuser;          // frame_end
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    zigzag_row_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pixel words waiting to be sent, and output pixels the block still owes
    logic [PIX_W-1:0] src_pixels[$];
    res_t             due_pixels[$];

    // Shadow of the block: registers, window of the last four pixels, position
    logic [DIM_W-1:0]             width_reg  = IMAGE_WIDTH_RESET;
    logic [DIM_W-1:0]             height_reg = IMAGE_HEIGHT_RESET;
    logic [3:0][PIX_W-1:0]        recent_px  = '0;   // newest at [0]
    int                           col_cnt    = 0;
    int                           row_cnt    = 0;

    int  cycle_cnt      = 0;
    int  words_in       = 0;
    int  words_out      = 0;
    int  row_ends       = 0;
    int  frame_ends     = 0;
    int  mismatches     = 0;
    int  settings_used  = 0;
    int  mode_hits[4]   = '{0, 0, 0, 0};
    bit  hold_off       = 1'b0;
    bit  pressure_armed = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Timeout watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d output pixels outstanding",
                     cycle_cnt, due_pixels.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Random idle cycle, except inside the quiet window
    function automatic bit roll_idle();
        if (cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END) return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    // Width and height as the block uses them: 0 reads as 1, above MAX_DIM clips
    function automatic int eff_dim(logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Value of the output pixel at (row, col); taps[0] is col-2, taps[4] col+2
    function automatic logic [PIX_W-1:0] filtered_value(int row, int col, int w, int h,
                                                        logic [NTAPS-1:0][PIX_W-1:0] taps);
        mode_t            mode;
        int               sum;
        logic [PIX_W-1:0] px;
        if (row < 2 || row + 2 >= h || col < 2 || col + 2 >= w) begin
            mode = MODE_WHITE;
        end else begin
            case (row % 4)
                0, 2:    mode = MODE_MEAN;
                1:       mode = MODE_LEFT;
                default: mode = MODE_RIGHT;
            endcase
        end
        mode_hits[mode]++;
        for (int k = 0; k < NCHAN; k++) begin
            case (mode)
                MODE_WHITE: px[CHAN_W*k +: CHAN_W] = WHITE;
                MODE_MEAN: begin
                    sum = 0;
                    for (int t = 0; t < NTAPS; t++) sum += taps[t][CHAN_W*k +: CHAN_W];
                    px[CHAN_W*k +: CHAN_W] = CHAN_W'(sum / 5);
                end
                MODE_LEFT:  px[CHAN_W*k +: CHAN_W] = taps[0][CHAN_W*k +: CHAN_W];
                default:    px[CHAN_W*k +: CHAN_W] = taps[4][CHAN_W*k +: CHAN_W];
            endcase
        end
        return px;
    endfunction

    // Advance the shadow by one accepted pixel and queue the output pixels it releases:
    // normally the one two columns back, at a row's last input everything pending.
    function automatic void take_pixel(logic [PIX_W-1:0] px);
        int                          w, h, c, r;
        bit                          last_col, last_row, fin;
        logic [NTAPS-1:0][PIX_W-1:0] taps;
        res_t                        due;
        w        = eff_dim(width_reg);
        h        = eff_dim(height_reg);
        c        = col_cnt;
        r        = row_cnt;
        last_col = c + 1 >= w;
        last_row = r + 1 >= h;
        taps     = {px, recent_px[0], recent_px[1], recent_px[2], recent_px[3]};
        if (c >= 2 || last_col) begin
            for (int col = (c >= 2) ? c - 2 : 0; col <= c; col++) begin
                fin           = last_col && col == c;
                due.pix       = filtered_value(r, col, w, h, taps);
                due.row_end   = fin;
                due.frame_end = fin && last_row;
                due_pixels.push_back(due);
                if (!last_col) break;
            end
        end
        recent_px = {recent_px[2:0], px};
        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    // Driver: hold the word until taken, then offer the next one or idle
    always @(posedge aclk) begin
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_pixel(s_tdata);
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                offer = src_pixels.size() > 0 && !roll_idle();
                if (offer) s_tdata <= src_pixels.pop_front();
                s_tvalid <= offer;
            end
        end
    end

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("Mismatch at output word %0d: %s expected %0d, got %0d",
                         words_out, field, want, got);
        end
    endfunction

    // Monitor: compare every output word with the oldest owed pixel
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_out++;
                if (m_tlast) row_ends++;
                if (m_tuser) frame_ends++;
                if (due_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("Unexpected output word %0d: data %h last %b user %b",
                                 words_out, m_tdata, m_tlast, m_tuser);
                end else begin
                    want = due_pixels.pop_front();
                    check_field("blue",      want.pix[7:0],   m_tdata[7:0]);
                    check_field("green",     want.pix[15:8],  m_tdata[15:8]);
                    check_field("red",       want.pix[23:16], m_tdata[23:16]);
                    check_field("row_end",   want.row_end,    m_tlast);
                    check_field("frame_end", want.frame_end,  m_tuser);
                end
            end
            m_tready <= !hold_off && !roll_idle();
        end
    end

    // Back-pressure: once armed, stall the receiver for a long stretch while
    // the sender keeps offering, so the block fills up and drops s_tready
    initial begin
        while (!pressure_armed) @(posedge aclk);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Write one register while the stream is idle; mirror it in the shadow
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = val;
            REG_IMAGE_HEIGHT: height_reg = val;
            default: ;
        endcase
        settings_used++;
    endtask

    // Wait until every word went in and every owed pixel came out, then let
    // a word that released nothing finish inside the block
    task automatic wait_idle();
        while (src_pixels.size() != 0 || s_tvalid || due_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void push_directed(inout int next, input int count);
        repeat (count) begin
            src_pixels.push_back(DIRECTED_WORDS[next]);
            next++;
        end
    endfunction

    // Random dimension: mostly small, sometimes the extremes and out-of-range values
    function automatic logic [DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)  return '0;
        if (roll < 12) return {DIM_W{1'b1}};
        if (roll < 15) return DIM_W'(MAX_DIM);
        if (roll < 22) return DIM_W'($urandom_range(13, 40));
        return DIM_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)  return '0;
        if (roll < 10) return '1;
        return PIX_W'($urandom());
    endfunction

    // Stimulus and end of run
    initial begin
        int next_word;
        int random_words;
        int burst;
        int w_eff;
        next_word    = 0;
        random_words = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset size, then each special case in turn. Counters carry
        // across register writes, which is what makes the short rows reach
        // the interior modes.
        push_directed(next_word, 3);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, '0);
        push_directed(next_word, 2);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(2));
        write_reg(REG_IMAGE_HEIGHT, {DIM_W{1'b1}});
        push_directed(next_word, 4);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(5));
        push_directed(next_word, 10);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(1));
        push_directed(next_word, 1);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(5));
        push_directed(next_word, 5);
        wait_idle();
        write_reg(REG_UNMAPPED, DIM_W'(7));
        write_reg(REG_IMAGE_WIDTH, DIM_W'(4));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
        push_directed(next_word, 4);
        wait_idle();

        // Long burst on an 8x8 frame under the receiver stall
        write_reg(REG_IMAGE_WIDTH, DIM_W'(8));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(8));
        repeat (120) src_pixels.push_back(pick_pixel());
        random_words += 120;
        pressure_armed <= 1'b1;
        wait_idle();

        // Random settings; most bursts are whole rows so frames complete,
        // the rest stop mid-row to exercise writes with counters in flight
        while (random_words < RANDOM_WORDS) begin
            if ($urandom_range(3) != 0) write_reg(REG_IMAGE_WIDTH, pick_dim());
            if ($urandom_range(3) != 0) write_reg(REG_IMAGE_HEIGHT, pick_dim());
            w_eff = eff_dim(width_reg);
            if (w_eff > 40)                  burst = $urandom_range(3, 24);
            else if ($urandom_range(99) < 20) burst = $urandom_range(1, 15);
            else                             burst = w_eff * $urandom_range(1, 6);
            if (burst > 80) burst = 80;
            repeat (burst) src_pixels.push_back(pick_pixel());
            random_words += burst;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (due_pixels.size() != 0) begin
            $display("%0d output pixels never arrived", due_pixels.size());
            mismatches += due_pixels.size();
        end
        $display("Sent %0d pixels over %0d register writes; checked %0d output pixels, %0d row ends, %0d frame ends",
                 words_in, settings_used, words_out, row_ends, frame_ends);
        $display("Pixels by mode: white %0d, mean %0d, left copy %0d, right copy %0d; %0d mismatches",
                 mode_hits[MODE_WHITE], mode_hits[MODE_MEAN], mode_hits[MODE_LEFT],
                 mode_hits[MODE_RIGHT], mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
